[rtl/core/clct_pkg.sv]
// ----------------------------------------------------------------------------
// Chunked load coverage tracker package
// Shared types, field widths and default sizes for the coverage tracker.
// ----------------------------------------------------------------------------
package clct_pkg;

  // Default storage sizes.
  localparam int unsigned ARTIFACT_BYTES_DEF = 4096;
  localparam int unsigned CHUNK_BYTES_DEF    = 256;

  // Coverage bits packed into one memory row.
  localparam int unsigned MAP_BITS = 8;

  // Field widths.
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // Value of the length register after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_CONFLICT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_FILL,
    S_CHECK,
    S_COMMIT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [BYTE_W-1:0]   byte_value;
    logic                chunk_end;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] covered_count;
    logic             complete;
  } out_item_t;

endpackage

[rtl/core/clct_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module clct_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/chunked_load_coverage_tracker_core.sv]
// ----------------------------------------------------------------------------
// Chunked load coverage tracker
// Collects artifact chunks byte by byte, checks each finished chunk against
// the bytes already loaded and commits the new ones into a coverage map.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries one chunk byte, or a restart when mode is set.
// Bytes are taken one per cycle into the chunk buffer while it is filling.
// The transfer with chunk_end set closes the chunk and produces exactly one
// output transfer with the status, the covered byte count and the complete
// flag. A closed chunk walks the buffer twice through the memories: a check
// pass and then, unless the check found a conflict, a commit pass, after
// which the result register is loaded. An oversized or out-of-bounds chunk
// skips both passes. A restart, and the release of reset, run a clearing
// pass over the coverage map, one row of eight bits per cycle. Input stays
// stalled during the passes and the clearing.
// The result sits in an output register; while the receiver stalls, new
// bytes of the next chunk are still taken, and only the result of that next
// chunk waits until the register is free. The length register may be
// written whenever the block is idle.
// ----------------------------------------------------------------------------
module chunked_load_coverage_tracker_core #(
  parameter int unsigned ARTIFACT_BYTES = clct_pkg::ARTIFACT_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES    = clct_pkg::CHUNK_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  clct_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output clct_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [clct_pkg::LEN_W-1:0]    cfg_data_i
);

  import clct_pkg::*;

  // Byte positions, coverage rows and the bit within a row.
  localparam int unsigned BIT_W    = $clog2(MAP_BITS);
  localparam int unsigned POS_W    = $clog2(ARTIFACT_BYTES);
  localparam int unsigned ROW_W    = POS_W - BIT_W;
  localparam int unsigned MAP_ROWS = (ARTIFACT_BYTES + MAP_BITS - 1) / MAP_BITS;
  // Covered byte counter and chunk fill counter.
  localparam int unsigned CNT_W    = $clog2(ARTIFACT_BYTES + 1);
  localparam int unsigned FILL_W   = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned BUF_AW   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  // Common width for length, bounds and count comparisons.
  localparam int unsigned CMP_W    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(MAP_ROWS - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CHUNK_BYTES);
  localparam logic [CMP_W-1:0]  LEN_MAX  = CMP_W'(ARTIFACT_BYTES);

  // Control state.
  state_e                 state_q, state_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   ovf_q, ovf_d;
  logic [FILL_W-1:0]      size_q, size_d;
  logic [FILL_W-1:0]      idx_q, idx_d;
  logic                   stg_v_q, stg_v_d;
  logic                   conflict_q, conflict_d;
  logic [CNT_W-1:0]       total_q, total_d;
  logic [ROW_W-1:0]       clr_row_q, clr_row_d;
  logic                   fwd_v_q, fwd_v_d;
  logic                   out_valid_q, out_valid_d;
  logic [LEN_W-1:0]       len_q;

  // Datapath registers.
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [POS_W-1:0]       start_q, start_d;
  logic [POS_W-1:0]       stg_pos_q, stg_pos_d;
  status_e                status_q, status_d;
  logic [ROW_W-1:0]       fwd_row_q, fwd_row_d;
  logic [MAP_BITS-1:0]    fwd_data_q, fwd_data_d;
  out_item_t              out_data_q, out_data_d;

  // Memory ports.
  logic                   buf_we;
  logic [BYTE_W-1:0]      buf_rdata;
  logic                   store_we;
  logic [BYTE_W-1:0]      store_rdata;
  logic                   cov_we;
  logic [ROW_W-1:0]       cov_waddr;
  logic [MAP_BITS-1:0]    cov_wdata;
  logic [MAP_BITS-1:0]    cov_rdata;

  // Derived signals.
  logic                   in_fire;
  logic                   issue;
  logic                   fill_full;
  logic [FILL_W-1:0]      size_new;
  logic [CMP_W-1:0]       eff_len;
  logic [CMP_W-1:0]       offset_w;
  logic [CMP_W-1:0]       chunk_stop;
  logic                   bad_chunk;
  logic [ROW_W-1:0]       stg_row;
  logic [MAP_BITS-1:0]    row_now;
  logic [MAP_BITS-1:0]    row_new;
  logic                   covered;

  assign in_stall_o  = (state_q != S_FILL);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The configured length is saturated to the size of the store.
  assign eff_len = (CMP_W'(len_q) > LEN_MAX) ? LEN_MAX : CMP_W'(len_q);

  // Bytes past the buffer capacity are dropped and mark the chunk oversized.
  assign fill_full  = (fill_q == FILL_MAX);
  assign size_new   = fill_full ? fill_q : fill_q + 1'b1;
  assign offset_w   = CMP_W'(in_data_i.chunk_offset);
  assign chunk_stop = offset_w + CMP_W'(size_new);
  assign bad_chunk  = ovf_q || fill_full || (chunk_stop > eff_len);

  // The pass walks the chunk while entries remain to be issued.
  assign issue = (idx_q != size_q);

  // Second pipeline stage: memory data for the entry issued in the previous cycle.
  // The coverage row written in the previous cycle is not yet visible in the
  // read data, so it is forwarded when the same row comes up again.
  assign stg_row = stg_pos_q[POS_W-1:BIT_W];
  assign row_now = (fwd_v_q && (fwd_row_q == stg_row)) ? fwd_data_q : cov_rdata;
  assign covered = row_now[stg_pos_q[BIT_W-1:0]];
  assign row_new = row_now | (MAP_BITS'(1) << stg_pos_q[BIT_W-1:0]);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    size_d      = size_q;
    idx_d       = idx_q;
    stg_v_d     = 1'b0;
    conflict_d  = conflict_q;
    total_d     = total_q;
    clr_row_d   = clr_row_q;
    fwd_v_d     = 1'b0;
    pos_d       = pos_q;
    start_d     = start_q;
    stg_pos_d   = stg_pos_q;
    status_d    = status_q;
    fwd_row_d   = fwd_row_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    buf_we      = 1'b0;
    store_we    = 1'b0;
    cov_we      = 1'b0;
    cov_waddr   = stg_row;
    cov_wdata   = row_new;

    unique case (state_q)
      S_CLEAR: begin
        cov_we    = 1'b1;
        cov_waddr = clr_row_q;
        cov_wdata = '0;
        clr_row_d = clr_row_q + 1'b1;
        if (clr_row_q == LAST_ROW) begin
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        if (in_fire) begin
          if (in_data_i.mode) begin
            total_d   = '0;
            fill_d    = '0;
            ovf_d     = 1'b0;
            clr_row_d = '0;
            state_d   = S_CLEAR;
          end else begin
            if (fill_full) begin
              ovf_d = 1'b1;
            end else begin
              buf_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
            if (in_data_i.chunk_end) begin
              fill_d     = '0;
              ovf_d      = 1'b0;
              size_d     = size_new;
              idx_d      = '0;
              start_d    = offset_w[POS_W-1:0];
              pos_d      = offset_w[POS_W-1:0];
              conflict_d = 1'b0;
              if (bad_chunk) begin
                status_d = STATUS_INVALID;
                state_d  = S_RESULT;
              end else begin
                state_d = S_CHECK;
              end
            end
          end
        end
      end

      S_CHECK: begin
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          pos_d     = pos_q + 1'b1;
          stg_v_d   = 1'b1;
          stg_pos_d = pos_q;
        end
        if (stg_v_q && covered && (store_rdata != buf_rdata)) begin
          conflict_d = 1'b1;
        end
        if (!issue && !stg_v_q) begin
          if (conflict_q) begin
            status_d = STATUS_CONFLICT;
            state_d  = S_RESULT;
          end else begin
            idx_d   = '0;
            pos_d   = start_q;
            state_d = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          pos_d     = pos_q + 1'b1;
          stg_v_d   = 1'b1;
          stg_pos_d = pos_q;
        end
        if (stg_v_q) begin
          cov_we     = 1'b1;
          fwd_v_d    = 1'b1;
          fwd_row_d  = stg_row;
          fwd_data_d = row_new;
          if (!covered) begin
            store_we = 1'b1;
            total_d  = total_q + 1'b1;
          end
        end
        if (!issue && !stg_v_q) begin
          status_d = STATUS_ACCEPTED;
          state_d  = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = status_q;
          out_data_d.covered_count = LEN_W'(total_q);
          out_data_d.complete      = (CMP_W'(total_q) == eff_len);
          state_d                  = S_FILL;
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      size_q      <= '0;
      idx_q       <= '0;
      stg_v_q     <= 1'b0;
      conflict_q  <= 1'b0;
      total_q     <= '0;
      clr_row_q   <= '0;
      fwd_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      len_q       <= LEN_RESET;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      size_q      <= size_d;
      idx_q       <= idx_d;
      stg_v_q     <= stg_v_d;
      conflict_q  <= conflict_d;
      total_q     <= total_d;
      clr_row_q   <= clr_row_d;
      fwd_v_q     <= fwd_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    start_q    <= start_d;
    stg_pos_q  <= stg_pos_d;
    status_q   <= status_d;
    fwd_row_q  <= fwd_row_d;
    fwd_data_q <= fwd_data_d;
    out_data_q <= out_data_d;
  end

  // Chunk buffer: filled at the fill count, read by both passes.
  clct_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CHUNK_BYTES)
  ) u_chunk_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (fill_q[BUF_AW-1:0]),
    .wdata_i (in_data_i.byte_value),
    .raddr_i (idx_q[BUF_AW-1:0]),
    .rdata_o (buf_rdata)
  );

  // Artifact bytes, read in the check pass and written in the commit pass.
  clct_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ARTIFACT_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (stg_pos_q),
    .wdata_i (buf_rdata),
    .raddr_i (pos_q),
    .rdata_o (store_rdata)
  );

  // Coverage map, eight positions to a row.
  clct_ram #(
    .WIDTH (MAP_BITS),
    .DEPTH (MAP_ROWS)
  ) u_cov_map (
    .clk_i   (clk_i),
    .we_i    (cov_we),
    .waddr_i (cov_waddr),
    .wdata_i (cov_wdata),
    .raddr_i (pos_q[POS_W-1:BIT_W]),
    .rdata_o (cov_rdata)
  );

  // The covered count can never pass the number of distinct positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(total_q) <= LEN_MAX)
    else $error("covered count exceeds the artifact size");

  // A result only appears when leaving the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result raised outside the result state");

  // The count changes only during a commit pass or a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK || state_q == S_RESULT) |=> $stable(total_q))
    else $error("covered count changed outside a commit");

endmodule
